### sv/image_scaler_bilinear_assert.svh
// Assertion macros shared by the image scaler modules.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef IMAGE_SCALER_BILINEAR_ASSERT_SVH
`define IMAGE_SCALER_BILINEAR_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ISB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("isb: same-cycle check failed");
`define ISB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("isb: next-cycle check failed");
`else
`define ISB_ASSERT_IMPL(label, ante, cons)
`define ISB_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### sv/isb_pkg.sv
// Shared types and constants for the bilinear image scaler.
// No dependencies.
`default_nettype none
package isb_pkg;

	localparam int COORD_W    = 12;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 10;
	localparam int STEP_W     = 16;
	localparam int POS_W      = COORD_W + STEP_W;
	localparam int LIM_W      = 13;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int CNT_W      = 3;
	localparam int PADDR_W    = 5;
	localparam int PDATA_W    = 32;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_SRC_COLS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_ROWS = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_STEP_H   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_STEP_V   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd4;

	localparam logic [DIM_W-1:0]  RST_SRC_COLS = 10'd512;
	localparam logic [DIM_W-1:0]  RST_SRC_ROWS = 10'd512;
	localparam logic [STEP_W-1:0] RST_STEP     = 16'd4096;

	localparam logic OP_QUERY      = 1'b1;
	localparam logic MODE_BILINEAR = 1'b1;

	typedef struct packed {
		logic [DIM_W-1:0]  cols;
		logic [DIM_W-1:0]  rows;
		logic [STEP_W-1:0] step_h;
		logic [STEP_W-1:0] step_v;
		logic              mode;
	} isb_cfg_t;

	typedef struct packed {
		logic               query;
		logic               ok;
		logic               bilinear;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pix;
	} isb_item_t;

	typedef struct packed {
		logic               first;
		logic               last;
		logic               ok;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} isb_tag_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel;
		logic               ok;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} isb_res_t;

endpackage
`default_nettype wire

### sv/image_scaler_bilinear.sv
// Path: a query result passes the map stages, the store read registers, the blend product
// register and the result queue, with four store reads in bilinear mode; loads produce no result.
// Throughput: loads 1 item per cycle while no query holds the store; nearest or out-of-range
// queries are limited by the four result credits; bilinear queries need four store reads each.
// Reset: config registers return to defaults, pipeline and result queue empty;
// the frame store is not cleared.
`default_nettype none
module image_scaler_bilinear import isb_pkg::*; #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRACTION_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic               operation,
	input  logic [COORD_W-1:0] row_index,
	input  logic [COORD_W-1:0] column_index,
	input  logic [PIX_W-1:0]   pixel_in,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               in_range,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_column
);

	localparam int AW = $clog2(MAX_ROWS * MAX_COLUMNS);
	localparam int WW = 2 * FRACTION_BITS + 1;

	isb_cfg_t               cfg_q;
	logic                   cfg_wr;
	logic [REG_IDX_W-1:0]   reg_idx;

	logic                   map_valid, map_take, credit_ok, reserve;
	isb_item_t              map_item;
	logic [3:0][AW-1:0]     map_addr;
	logic [3:0][WW-1:0]     map_wt;
	logic                   rd_valid;
	isb_tag_t               rd_tag;
	logic [WW-1:0]          rd_wt;
	logic [PIX_W-1:0]       rd_data;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols   <= RST_SRC_COLS;
			cfg_q.rows   <= RST_SRC_ROWS;
			cfg_q.step_h <= RST_STEP;
			cfg_q.step_v <= RST_STEP;
			cfg_q.mode   <= MODE_BILINEAR;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_SRC_COLS: cfg_q.cols   <= pwdata[DIM_W-1:0];
				REG_SRC_ROWS: cfg_q.rows   <= pwdata[DIM_W-1:0];
				REG_STEP_H:   cfg_q.step_h <= pwdata[STEP_W-1:0];
				REG_STEP_V:   cfg_q.step_v <= pwdata[STEP_W-1:0];
				REG_MODE:     cfg_q.mode   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SRC_COLS: prdata = PDATA_W'(cfg_q.cols);
			REG_SRC_ROWS: prdata = PDATA_W'(cfg_q.rows);
			REG_STEP_H:   prdata = PDATA_W'(cfg_q.step_h);
			REG_STEP_V:   prdata = PDATA_W'(cfg_q.step_v);
			REG_MODE:     prdata = PDATA_W'(cfg_q.mode);
			default:      prdata = '0;
		endcase
	end

	isb_map #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_map (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.row_index(row_index),
		.column_index(column_index),
		.pixel_in(pixel_in),
		.map_valid(map_valid),
		.map_item(map_item),
		.map_addr(map_addr),
		.map_wt(map_wt),
		.map_take(map_take)
	);

	isb_store #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.MAX_ROWS(MAX_ROWS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(map_valid),
		.item(map_item),
		.addr(map_addr),
		.wt(map_wt),
		.credit_ok(credit_ok),
		.item_take(map_take),
		.reserve(reserve),
		.rd_valid(rd_valid),
		.rd_tag(rd_tag),
		.rd_wt(rd_wt),
		.rd_data(rd_data)
	);

	isb_blend #(
		.FRACTION_BITS(FRACTION_BITS)
	) u_blend (
		.clk(clk),
		.arst_n(arst_n),
		.rd_valid(rd_valid),
		.rd_tag(rd_tag),
		.rd_wt(rd_wt),
		.rd_data(rd_data),
		.reserve(reserve),
		.credit_ok(credit_ok),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pixel_out(pixel_out),
		.in_range(in_range),
		.out_row(out_row),
		.out_column(out_column)
	);

endmodule
`default_nettype wire

### sv/isb_map.sv
// Coordinate mapping pipeline: scale products, bounds, store addresses, blend weights.
// Depends on isb_pkg.
`default_nettype none
module isb_map import isb_pkg::*; #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRACTION_BITS = 12,
	localparam int AW = $clog2(MAX_ROWS * MAX_COLUMNS),
	localparam int WW = 2 * FRACTION_BITS + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  isb_cfg_t               cfg,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic                   operation,
	input  logic [COORD_W-1:0]     row_index,
	input  logic [COORD_W-1:0]     column_index,
	input  logic [PIX_W-1:0]       pixel_in,
	output logic                   map_valid,
	output isb_item_t              map_item,
	output logic [3:0][AW-1:0]     map_addr,
	output logic [3:0][WW-1:0]     map_wt,
	input  logic                   map_take
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLUMNS);
	localparam int UW = POS_W - FRACTION_BITS;
	localparam int FW = FRACTION_BITS + 1;

	localparam logic [FW-1:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};
	localparam logic [WW-1:0] ONE_SQ  = {1'b1, {2*FRACTION_BITS{1'b0}}};

	logic                   vld_s1, vld_s2, vld_s3;
	logic                   op_s1, op_s2;
	logic [COORD_W-1:0]     row_s1, row_s2, col_s1, col_s2;
	logic [PIX_W-1:0]       pix_s1, pix_s2;
	logic [POS_W-1:0]       ypos_s2, xpos_s2;
	isb_item_t              item_s3;
	logic [3:0][AW-1:0]     addr_s3;
	logic [3:0][WW-1:0]     wt_s3;

	logic                   rdy1, rdy2, rdy3;
	logic [POS_W-1:0]       ypos_c, xpos_c;
	logic [UW-1:0]          y0, x0;
	logic [FRACTION_BITS-1:0] fy, fx;
	logic [UW:0]            y1, x1;
	logic [LIM_W-1:0]       nrows, ncols;
	logic                   ok_near, ok_bil, ok_load, is_query;
	logic [RW-1:0]          r0;
	logic [CW-1:0]          c0;
	logic                   dy, dx;
	logic [AW-1:0]          base, a10, a01, a11;
	logic [FW-1:0]          gy, gx, fye, fxe;
	logic [2*FW-1:0]        p00, p10, p01, p11;
	isb_item_t              item_c;

	assign rdy3 = !vld_s3 || map_take;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;
	assign item_stall = !rdy1;

	assign ypos_c = row_s1 * cfg.step_v;
	assign xpos_c = col_s1 * cfg.step_h;

	assign is_query = (op_s2 == OP_QUERY);
	assign y0 = ypos_s2[POS_W-1:FRACTION_BITS];
	assign x0 = xpos_s2[POS_W-1:FRACTION_BITS];
	assign fy = ypos_s2[FRACTION_BITS-1:0];
	assign fx = xpos_s2[FRACTION_BITS-1:0];
	assign y1 = {1'b0, y0} + (UW+1)'(fy != '0);
	assign x1 = {1'b0, x0} + (UW+1)'(fx != '0);

	assign nrows = ({3'b0, cfg.rows} > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS) : {3'b0, cfg.rows};
	assign ncols = ({3'b0, cfg.cols} > LIM_W'(MAX_COLUMNS)) ? LIM_W'(MAX_COLUMNS)
		: {3'b0, cfg.cols};

	assign ok_near = ({1'b0, y0} < (UW+1)'(nrows)) && ({1'b0, x0} < (UW+1)'(ncols));
	assign ok_bil  = (y1 < (UW+1)'(nrows)) && (x1 < (UW+1)'(ncols));
	assign ok_load = ({1'b0, row_s2} < LIM_W'(MAX_ROWS)) && ({1'b0, col_s2} < LIM_W'(MAX_COLUMNS));

	assign r0 = is_query ? y0[RW-1:0] : row_s2[RW-1:0];
	assign c0 = is_query ? x0[CW-1:0] : col_s2[CW-1:0];
	assign dy = (fy != '0);
	assign dx = (fx != '0);

	assign base = AW'(r0) * AW'(MAX_COLUMNS) + AW'(c0);
	assign a10  = base + (dy ? AW'(MAX_COLUMNS) : '0);
	assign a01  = base + AW'(dx);
	assign a11  = a10 + AW'(dx);

	assign fye = {1'b0, fy};
	assign fxe = {1'b0, fx};
	assign gy  = ONE_FIX - fye;
	assign gx  = ONE_FIX - fxe;
	assign p00 = gy * gx;
	assign p10 = fye * gx;
	assign p01 = gy * fxe;
	assign p11 = fye * fxe;

	always_comb begin
		item_c.query    = is_query;
		item_c.bilinear = (cfg.mode == MODE_BILINEAR);
		item_c.ok       = is_query ? ((cfg.mode == MODE_BILINEAR) ? ok_bil : ok_near) : ok_load;
		item_c.row      = row_s2;
		item_c.col      = col_s2;
		item_c.pix      = pix_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= item_valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && item_valid) begin
			op_s1  <= operation;
			row_s1 <= row_index;
			col_s1 <= column_index;
			pix_s1 <= pixel_in;
		end
		if (rdy2 && vld_s1) begin
			op_s2   <= op_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			pix_s2  <= pix_s1;
			ypos_s2 <= ypos_c;
			xpos_s2 <= xpos_c;
		end
		if (rdy3 && vld_s2) begin
			item_s3    <= item_c;
			addr_s3[0] <= base;
			addr_s3[1] <= a10;
			addr_s3[2] <= a01;
			addr_s3[3] <= a11;
			wt_s3[0]   <= (cfg.mode == MODE_BILINEAR) ? WW'(p00) : ONE_SQ;
			wt_s3[1]   <= WW'(p10);
			wt_s3[2]   <= WW'(p01);
			wt_s3[3]   <= WW'(p11);
		end
	end

	assign map_valid = vld_s3;
	assign map_item  = item_s3;
	assign map_addr  = addr_s3;
	assign map_wt    = wt_s3;

endmodule
`default_nettype wire

### sv/isb_store.sv
// Frame store and access sequencer: one write per in-range load, one or four reads per in-range query.
// Depends on isb_pkg and image_scaler_bilinear_assert.svh.
`default_nettype none
`include "image_scaler_bilinear_assert.svh"
module isb_store import isb_pkg::*; #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_ROWS = 512,
	parameter int FRACTION_BITS = 12,
	localparam int AW = $clog2(MAX_ROWS * MAX_COLUMNS),
	localparam int WW = 2 * FRACTION_BITS + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  isb_item_t          item,
	input  logic [3:0][AW-1:0] addr,
	input  logic [3:0][WW-1:0] wt,
	input  logic               credit_ok,
	output logic               item_take,
	output logic               reserve,
	output logic               rd_valid,
	output isb_tag_t           rd_tag,
	output logic [WW-1:0]      rd_wt,
	output logic [PIX_W-1:0]   rd_data
);

	localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;

	logic [PIX_W-1:0] mem [DEPTH];

	logic               busy_q;
	logic [1:0]         step_q, last_q;
	isb_item_t          item_q;
	logic [3:0][AW-1:0] addr_q;
	logic [3:0][WW-1:0] wt_q;

	logic               rd_valid_s1;
	isb_tag_t           rd_tag_s1;
	logic [WW-1:0]      rd_wt_s1;
	logic [PIX_W-1:0]   rd_data_s1;

	logic               at_last, mem_we, mem_re;
	logic [AW-1:0]      mem_addr;
	isb_tag_t           tag_c;

	assign at_last   = (step_q == last_q);
	assign item_take = item_valid && (!busy_q || at_last) && (!item.query || credit_ok);
	assign reserve   = item_take && item.query;

	assign mem_addr = addr_q[step_q];
	assign mem_we   = busy_q && !item_q.query && item_q.ok;
	assign mem_re   = busy_q && item_q.query && item_q.ok;

	always_comb begin
		tag_c.first = (step_q == 2'd0);
		tag_c.last  = at_last;
		tag_c.ok    = item_q.ok;
		tag_c.row   = item_q.row;
		tag_c.col   = item_q.col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= 2'd0;
			last_q      <= 2'd0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= busy_q && item_q.query;
			if (item_take) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
				last_q <= (item.query && item.ok && item.bilinear) ? 2'd3 : 2'd0;
			end else if (busy_q && at_last) begin
				busy_q <= 1'b0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_q <= item;
			addr_q <= addr;
			wt_q   <= wt;
		end
		rd_tag_s1 <= tag_c;
		rd_wt_s1  <= wt_q[step_q];
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= item_q.pix;
		if (mem_re) rd_data_s1 <= mem[mem_addr];
	end

	assign rd_valid = rd_valid_s1;
	assign rd_tag   = rd_tag_s1;
	assign rd_wt    = rd_wt_s1;
	assign rd_data  = rd_data_s1;

	`ISB_ASSERT_IMPL(a_take_only_on_last, item_take && busy_q, at_last)
	`ISB_ASSERT_NEXT(a_step_advances, busy_q && !at_last, busy_q && step_q == $past(step_q) + 2'd1)
	`ISB_ASSERT_IMPL(a_write_single_step, mem_we, step_q == 2'd0 && last_q == 2'd0)

endmodule
`default_nettype wire

### sv/isb_blend.sv
// Weighted accumulate of neighbor reads and result queue with credit count.
// Depends on isb_pkg and image_scaler_bilinear_assert.svh.
`default_nettype none
`include "image_scaler_bilinear_assert.svh"
module isb_blend import isb_pkg::*; #(
	parameter int FRACTION_BITS = 12,
	localparam int WW = 2 * FRACTION_BITS + 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_valid,
	input  isb_tag_t           rd_tag,
	input  logic [WW-1:0]      rd_wt,
	input  logic [PIX_W-1:0]   rd_data,
	input  logic               reserve,
	output logic               credit_ok,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               in_range,
	output logic [COORD_W-1:0] out_row,
	output logic [COORD_W-1:0] out_column
);

	localparam int PW = WW + PIX_W;

	logic               vld_s2;
	isb_tag_t           tag_s2;
	logic [PW-1:0]      prod_s2;
	logic [PW-1:0]      acc_q;
	isb_res_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   fill_q, res_cnt_q;

	logic [PW-1:0]      prod_c, sum_c;
	logic               push, pop;
	isb_res_t           res_c, head;

	assign prod_c = rd_data * rd_wt;
	assign sum_c  = tag_s2.first ? prod_s2 : acc_q + prod_s2;
	assign push   = vld_s2 && tag_s2.last;

	always_comb begin
		res_c.pixel = tag_s2.ok ? sum_c[2*FRACTION_BITS +: PIX_W] : '0;
		res_c.ok    = tag_s2.ok;
		res_c.row   = tag_s2.row;
		res_c.col   = tag_s2.col;
	end

	assign result_valid = (fill_q != '0);
	assign pop          = result_valid && !result_stall;
	assign credit_ok    = (res_cnt_q != CNT_W'(FIFO_DEPTH));

	assign head       = fifo_q[rd_ptr_q];
	assign pixel_out  = head.pixel;
	assign in_range   = head.ok;
	assign out_row    = head.row;
	assign out_column = head.col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2    <= 1'b0;
			wr_ptr_q  <= '0;
			rd_ptr_q  <= '0;
			fill_q    <= '0;
			res_cnt_q <= '0;
		end else begin
			vld_s2    <= rd_valid;
			fill_q    <= fill_q + CNT_W'(push) - CNT_W'(pop);
			res_cnt_q <= res_cnt_q + CNT_W'(reserve) - CNT_W'(pop);
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		tag_s2  <= rd_tag;
		prod_s2 <= prod_c;
		if (vld_s2) acc_q <= sum_c;
		if (push) fifo_q[wr_ptr_q] <= res_c;
	end

	`ISB_ASSERT_IMPL(a_credit_bounds, 1'b1, res_cnt_q >= fill_q && res_cnt_q <= CNT_W'(FIFO_DEPTH))
	`ISB_ASSERT_IMPL(a_no_overflow, push, fill_q != CNT_W'(FIFO_DEPTH) || pop)
	`ISB_ASSERT_NEXT(a_first_after_last, vld_s2 && tag_s2.last, !vld_s2 || tag_s2.first)

endmodule
`default_nettype wire

### dv/image_scaler_bilinear_tb.sv
// Self-checking testbench for image_scaler_bilinear: loads source pixels, queries scaled
// pixels under a range of sizes, steps and modes, and checks each result against a table or a predictor.
// Depends on isb_pkg and the image_scaler_bilinear RTL.
module image_scaler_bilinear_tb;
	import isb_pkg::*;

	localparam int MAX_COLS = 512;
	localparam int MAX_ROWS = 512;
	localparam int FRAC = 12;
	localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int WIN = 16;
	localparam int N_PHASES = 14;
	localparam int BODY_ITEMS = 85;
	localparam int SETTLE_CYCLES = 12;
	localparam int QUIET_LIMIT = 2000;
	localparam logic OP_LOAD = 1'b0;
	localparam logic MODE_NEAREST = 1'b0;

	typedef struct packed {
		logic               op;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pix;
		logic               known;
		logic [PIX_W-1:0]   want_pix;
		logic               want_ok;
	} directed_row_t;

	localparam int N_DIRECTED = 21;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{OP_LOAD,  12'd0,    12'd0,    8'h00, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd0,    12'd1,    8'hFF, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd1,    12'd0,    8'h80, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd1,    12'd1,    8'h7F, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd511,  12'd511,  8'hA5, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd511,  12'd0,    8'h5A, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd0,    12'd511,  8'hC3, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd4095, 12'd4095, 8'h11, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd512,  12'd0,    8'h22, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd0,    12'd512,  8'h33, 1'b0, 8'h00, 1'b0},
		'{OP_LOAD,  12'd2048, 12'd2048, 8'h44, 1'b0, 8'h00, 1'b0},
		'{OP_QUERY, 12'd0,    12'd0,    8'hFF, 1'b1, 8'h00, 1'b1},
		'{OP_QUERY, 12'd0,    12'd1,    8'h00, 1'b1, 8'hFF, 1'b1},
		'{OP_QUERY, 12'd1,    12'd0,    8'h00, 1'b1, 8'h80, 1'b1},
		'{OP_QUERY, 12'd1,    12'd1,    8'h00, 1'b1, 8'h7F, 1'b1},
		'{OP_QUERY, 12'd511,  12'd511,  8'h00, 1'b1, 8'hA5, 1'b1},
		'{OP_QUERY, 12'd511,  12'd0,    8'h00, 1'b1, 8'h5A, 1'b1},
		'{OP_QUERY, 12'd0,    12'd511,  8'h00, 1'b1, 8'hC3, 1'b1},
		'{OP_QUERY, 12'd512,  12'd0,    8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_QUERY, 12'd0,    12'd512,  8'h00, 1'b1, 8'h00, 1'b0},
		'{OP_QUERY, 12'd4095, 12'd4095, 8'hFF, 1'b1, 8'h00, 1'b0}
	};

	logic               clk;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic               operation = OP_LOAD;
	logic [COORD_W-1:0] row_index = '0;
	logic [COORD_W-1:0] column_index = '0;
	logic [PIX_W-1:0]   pixel_in = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic [PIX_W-1:0]   pixel_out;
	logic               in_range;
	logic [COORD_W-1:0] out_row;
	logic [COORD_W-1:0] out_column;

	isb_cfg_t         cfg;
	bit               written_map [STORE_DEPTH];
	logic [PIX_W-1:0] frame_copy [STORE_DEPTH];
	isb_res_t         pending_results [$];
	int               failures = 0;
	int               gap_odds = 0;
	int               stall_odds = 0;
	int               stall_left = 0;
	int               quiet_cycles = 0;

	image_scaler_bilinear dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.operation(operation),
		.row_index(row_index),
		.column_index(column_index),
		.pixel_in(pixel_in),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.pixel_out(pixel_out),
		.in_range(in_range),
		.out_row(out_row),
		.out_column(out_column)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int cell_of(input int r, input int c);
		return r * MAX_COLS + c;
	endfunction

	// Source mapping and nearest pick or bilinear blend; safe drops when a needed entry was never loaded.
	function automatic isb_res_t scale_pixel(input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, output bit safe);
		logic [POS_W-1:0]      u, v;
		logic [POS_W-FRAC:0]   u0, v0, u1, v1;
		logic [FRAC-1:0]       fu, fv;
		logic [FRAC:0]         gu, gv;
		logic [DIM_W:0]        n_r, n_c;
		logic [PIX_W-1:0]      q11, q21, q12, q22;
		logic [2*FRAC+9:0]     blend;
		isb_res_t              res;
		n_r = (cfg.rows > MAX_ROWS) ? (DIM_W+1)'(MAX_ROWS) : (DIM_W+1)'(cfg.rows);
		n_c = (cfg.cols > MAX_COLS) ? (DIM_W+1)'(MAX_COLS) : (DIM_W+1)'(cfg.cols);
		u = r * cfg.step_v;
		v = c * cfg.step_h;
		u0 = (POS_W-FRAC+1)'(u >> FRAC);
		v0 = (POS_W-FRAC+1)'(v >> FRAC);
		fu = u[FRAC-1:0];
		fv = v[FRAC-1:0];
		u1 = u0 + (fu != 0);
		v1 = v0 + (fv != 0);
		res.row = r;
		res.col = c;
		res.pixel = '0;
		safe = 1'b1;
		if (cfg.mode == MODE_NEAREST) begin
			res.ok = (u0 < n_r) && (v0 < n_c);
			if (res.ok) begin
				safe = written_map[cell_of(u0, v0)];
				res.pixel = frame_copy[cell_of(u0, v0)];
			end
		end else begin
			res.ok = (u1 < n_r) && (v1 < n_c);
			if (res.ok) begin
				safe = written_map[cell_of(u0, v0)] && written_map[cell_of(u1, v0)]
					&& written_map[cell_of(u0, v1)] && written_map[cell_of(u1, v1)];
				q11 = frame_copy[cell_of(u0, v0)];
				q21 = frame_copy[cell_of(u1, v0)];
				q12 = frame_copy[cell_of(u0, v1)];
				q22 = frame_copy[cell_of(u1, v1)];
				gu = (FRAC+1)'((1 << FRAC) - fu);
				gv = (FRAC+1)'((1 << FRAC) - fv);
				blend = q11 * gu * gv + q21 * fu * gv + q12 * gu * fv + q22 * fu * fv;
				res.pixel = blend[2*FRAC +: PIX_W];
			end
		end
		return res;
	endfunction

	function automatic logic [DIM_W-1:0] pick_dim();
		if ($urandom_range(0, 7) == 0)
			return ($urandom_range(0, 1) == 0) ? DIM_W'(MAX_COLS) : '1;
		return DIM_W'($urandom_range(1, WIN));
	endfunction

	function automatic logic [STEP_W-1:0] pick_step();
		case ($urandom_range(0, 3))
		0: return STEP_W'($urandom_range(1, 65535));
		1: return STEP_W'($urandom_range(200, 2000));
		default: return STEP_W'($urandom_range(2048, 8192));
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input int hi);
		if ($urandom_range(0, 99) < 85)
			return COORD_W'($urandom_range(0, hi));
		return COORD_W'($urandom);
	endfunction

	task automatic send_item(input logic op, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic [PIX_W-1:0] pix,
			input bit known, input logic [PIX_W-1:0] want_pix, input logic want_ok);
		bit safe;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		item_valid <= 1'b1;
		operation <= op;
		row_index <= r;
		column_index <= c;
		pixel_in <= pix;
		do @(posedge clk); while (item_stall);
		if (op == OP_LOAD) begin
			if (r < MAX_ROWS && c < MAX_COLS) begin
				written_map[cell_of(r, c)] = 1'b1;
				frame_copy[cell_of(r, c)] = pix;
			end
		end else if (known)
			pending_results.push_back('{want_pix, want_ok, r, c});
		else
			pending_results.push_back(scale_pixel(r, c, safe));
	endtask

	task automatic drain_results();
		item_valid <= 1'b0;
		do @(negedge clk); while (pending_results.size() != 0);
		@(posedge clk);
	endtask

	task automatic settle();
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_SRC_COLS: cfg.cols = val[DIM_W-1:0];
		REG_SRC_ROWS: cfg.rows = val[DIM_W-1:0];
		REG_STEP_H: cfg.step_h = val[STEP_W-1:0];
		REG_STEP_V: cfg.step_v = val[STEP_W-1:0];
		REG_MODE: cfg.mode = val[0];
		default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [DIM_W-1:0] cols, input logic [DIM_W-1:0] rows,
			input logic [STEP_W-1:0] sh, input logic [STEP_W-1:0] sv, input logic mode);
		write_reg(REG_SRC_COLS, PDATA_W'(cols));
		write_reg(REG_SRC_ROWS, PDATA_W'(rows));
		write_reg(REG_STEP_H, PDATA_W'(sh));
		write_reg(REG_STEP_V, PDATA_W'(sv));
		write_reg(REG_MODE, PDATA_W'(mode));
	endtask

	// Receiver: random stall bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
			stall_left <= $urandom_range(0, 18);
			result_stall <= 1'b1;
		end else
			result_stall <= 1'b0;
	end

	always @(posedge clk) begin
		isb_res_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result: pixel_out %0d in_range %0b row %0d col %0d",
					$time, pixel_out, in_range, out_row, out_column);
			end else begin
				want = pending_results.pop_front();
				if (pixel_out !== want.pixel) begin
					failures++;
					$display("%0t: pixel_out expected %0d got %0d", $time, want.pixel, pixel_out);
				end
				if (in_range !== want.ok) begin
					failures++;
					$display("%0t: in_range expected %0b got %0b", $time, want.ok, in_range);
				end
				if (out_row !== want.row) begin
					failures++;
					$display("%0t: out_row expected %0d got %0d", $time, want.row, out_row);
				end
				if (out_column !== want.col) begin
					failures++;
					$display("%0t: out_column expected %0d got %0d", $time, want.col, out_column);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable))
				quiet_cycles <= 0;
			else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int                 p, k, t, choice, lim_r, lim_c, ext_r, ext_c, row_hi, col_hi;
		bit                 safe, found;
		logic [COORD_W-1:0] qr, qc;
		isb_res_t           probe;
		cfg = '{RST_SRC_COLS, RST_SRC_ROWS, RST_STEP, RST_STEP, MODE_BILINEAR};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_odds = 5;
		stall_odds = 10;
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].row, directed_rows[i].col,
				directed_rows[i].pix, directed_rows[i].known, directed_rows[i].want_pix,
				directed_rows[i].want_ok);

		for (p = 0; p < N_PHASES; p++) begin
			settle();
			case (p)
			0: set_config('1, '1, 16'd0, 16'd0, MODE_NEAREST);
			1: set_config(10'd0, 10'd7, RST_STEP, RST_STEP, MODE_BILINEAR);
			2: set_config(10'd9, 10'd0, RST_STEP, RST_STEP, MODE_NEAREST);
			3: set_config(10'd1, 10'd1, 16'hFFFF, 16'hFFFF, MODE_BILINEAR);
			4: set_config(10'd16, 10'd16, 16'd1, 16'd1, MODE_BILINEAR);
			5: set_config(10'd512, 10'd512, 16'd2048, 16'd2048, MODE_BILINEAR);
			6: set_config(10'd16, 10'd12, 16'd6144, 16'd5000, MODE_NEAREST);
			default: set_config(pick_dim(), pick_dim(), pick_step(), pick_step(),
				logic'($urandom_range(0, 1)));
			endcase

			if (p >= N_PHASES - 2) begin
				gap_odds = 0;
				stall_odds = 0;
			end else begin
				gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 12);
				stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(6, 30);
			end

			lim_r = (cfg.rows > MAX_ROWS) ? MAX_ROWS : cfg.rows;
			lim_c = (cfg.cols > MAX_COLS) ? MAX_COLS : cfg.cols;
			ext_r = (lim_r < WIN) ? lim_r : WIN;
			ext_c = (lim_c < WIN) ? lim_c : WIN;
			row_hi = (cfg.step_v == 0 || ext_r == 0) ? 4095 : ((ext_r << FRAC) - 1) / cfg.step_v;
			col_hi = (cfg.step_h == 0 || ext_c == 0) ? 4095 : ((ext_c << FRAC) - 1) / cfg.step_h;
			if (row_hi > 4095)
				row_hi = 4095;
			if (col_hi > 4095)
				col_hi = 4095;

			// fill the visible corner of the source before querying it
			for (k = 0; k < ext_r; k++)
				for (t = 0; t < ext_c; t++)
					if (!written_map[cell_of(k, t)])
						send_item(OP_LOAD, COORD_W'(k), COORD_W'(t), PIX_W'($urandom),
							1'b0, '0, 1'b0);

			for (k = 0; k < BODY_ITEMS; k++) begin
				if (p == 5 && k == BODY_ITEMS / 2)
					drain_results();
				choice = $urandom_range(0, 99);
				found = 1'b0;
				if (choice < 60) begin
					for (t = 0; t < 8 && !found; t++) begin
						qr = pick_coord(row_hi);
						qc = pick_coord(col_hi);
						probe = scale_pixel(qr, qc, safe);
						found = safe;
					end
				end
				if (found)
					send_item(OP_QUERY, qr, qc, PIX_W'($urandom), 1'b0, '0, 1'b0);
				else if (choice < 90 && ext_r != 0 && ext_c != 0)
					send_item(OP_LOAD, COORD_W'($urandom_range(0, ext_r - 1)),
						COORD_W'($urandom_range(0, ext_c - 1)), PIX_W'($urandom),
						1'b0, '0, 1'b0);
				else
					send_item(OP_LOAD, COORD_W'($urandom), COORD_W'($urandom),
						PIX_W'($urandom), 1'b0, '0, 1'b0);
			end
		end

		settle();
		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
